[rtl/core/acm_pkg.sv]
package acm_pkg;

  localparam int WordW = 16;

  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_STOP    = 3'd1;
  localparam logic [2:0] ST_BADOP   = 3'd2;
  localparam logic [2:0] ST_BADADDR = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;
  localparam logic [2:0] ST_PCPAST  = 3'd5;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_STEP    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_JMP    = 4'd5;
  localparam logic [3:0] OP_JMPN   = 4'd6;
  localparam logic [3:0] OP_JMPP   = 4'd7;
  localparam logic [3:0] OP_JMPZ   = 4'd8;
  localparam logic [3:0] OP_COPY   = 4'd9;
  localparam logic [3:0] OP_LOAD   = 4'd10;
  localparam logic [3:0] OP_STORE  = 4'd11;
  localparam logic [3:0] OP_INPUT  = 4'd12;
  localparam logic [3:0] OP_OUTPUT = 4'd13;
  localparam logic [3:0] OP_STOP   = 4'd14;

endpackage

[rtl/core/accumulator_machine_core.sv]
// load, restart and a halted step go straight to the result; a step fetches its words through
// the registered memory read port, and a divide runs the divider, one quotient bit per cycle
// one item at a time; the next input transfer is accepted only once the result has been taken
// after reset: a clearing pass zeroes the word memory,
// during which no item is accepted; pc, accumulator and halt code reset to zero
module accumulator_machine_core
  import acm_pkg::*;
#(
  parameter int MEM_WORDS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        address,
  input  logic signed [15:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [15:0]       program_counter,
  output logic signed [15:0] accumulator,
  output logic              input_taken,
  output logic              output_valid,
  output logic signed [15:0] output_value
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FOP   = 4'd2;
  localparam logic [3:0] S_DOP   = 4'd3;
  localparam logic [3:0] S_FA1   = 4'd4;
  localparam logic [3:0] S_FA2   = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_DATA  = 4'd7;
  localparam logic [3:0] S_ALU   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DIVF  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_WAIT1 = 4'd12;
  localparam logic [3:0] S_WAIT2 = 4'd13;

  logic [3:0] state;
  logic [WordW-1:0] mem [MEM_WORDS];
  logic [AW-1:0] rd_addr;
  logic [WordW-1:0] rd_data;
  logic mem_we;
  logic [AW-1:0] wr_addr;
  logic [WordW-1:0] wr_data;

  logic [AW:0] clr_cnt;
  logic [15:0] pc_reg, acc_reg;
  logic [2:0] halt_code;
  logic [15:0] in_value;
  logic [3:0] op;
  logic [15:0] a1, a2;
  logic [15:0] d1;
  logic taken, ovalid;
  logic [15:0] oval;

  // divider
  logic [15:0] quo, rem_r, dvs;
  logic [4:0] div_cnt;
  logic neg_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  function automatic logic in_mem(input logic [16:0] a);
    return a < 17'(MEM_WORDS);
  endfunction

  logic [16:0] pc_len_end;
  logic [1:0] len;
  logic [16:0] rem_sh;
  always_comb begin
    len = (op == OP_STOP) ? 2'd1 : (op == OP_COPY) ? 2'd3 : 2'd2;
    pc_len_end = {1'b0, pc_reg} + 17'(len) - 17'd1;
    rem_sh = {rem_r, quo[15]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pc_reg <= '0;
      acc_reg <= '0;
      halt_code <= ST_RUN;
      out_valid <= 1'b0;
      mem_we <= 1'b0;
      rd_addr <= '0;
    end else begin
      mem_we <= (state == S_CLEAR) ||
                (state == S_IDLE && in_valid && in_ready && kind == KIND_LOAD &&
                 in_mem({9'd0, address})) ||
                (state == S_ALU && (op == OP_COPY || op == OP_STORE || op == OP_INPUT));
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          wr_addr <= clr_cnt[AW-1:0];
          wr_data <= '0;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (AW+1)'(MEM_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            taken <= 1'b0;
            ovalid <= 1'b0;
            oval <= '0;
            in_value <= value;
            state <= (kind == KIND_STEP && halt_code == ST_RUN && in_mem({1'b0, pc_reg})) ?
                     S_FOP : S_OUT;
            if (kind == KIND_LOAD) begin
              if (in_mem({9'd0, address})) begin
                wr_addr <= AW'(address);
                wr_data <= value;
              end
            end else if (kind == KIND_RESTART) begin
              pc_reg <= '0;
              acc_reg <= '0;
              halt_code <= ST_RUN;
            end else if (kind == KIND_STEP && halt_code == ST_RUN) begin
              if (!in_mem({1'b0, pc_reg})) begin
                halt_code <= ST_PCPAST;
              end else begin
                rd_addr <= pc_reg[AW-1:0];
              end
            end
          end
        end
        S_FOP: state <= S_DOP;
        S_DOP: begin
          op <= rd_data[3:0];
          if (rd_data < 16'd1 || rd_data > 16'd14) begin
            halt_code <= ST_BADOP;
            state <= S_OUT;
          end else begin
            state <= S_FA1;
          end
        end
        S_FA1: begin
          if (!in_mem(pc_len_end)) begin
            halt_code <= ST_PCPAST;
            state <= S_OUT;
          end else if (op == OP_STOP) begin
            halt_code <= ST_STOP;
            state <= S_OUT;
          end else begin
            rd_addr <= AW'(pc_reg + 16'd1);
            state <= S_WAIT1;
          end
        end
        S_WAIT1: begin
          rd_addr <= AW'(pc_reg + 16'd2);
          state <= S_FA2;
        end
        S_FA2: begin
          a1 <= rd_data;
          rd_addr <= rd_data[AW-1:0];
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          a2 <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (op == OP_JMP || op == OP_JMPN || op == OP_JMPP || op == OP_JMPZ) begin
            state <= S_OUT;
            if (op == OP_JMP || (op == OP_JMPN && acc_reg[15]) ||
                (op == OP_JMPP && !acc_reg[15] && acc_reg != 16'd0) ||
                (op == OP_JMPZ && acc_reg == 16'd0)) begin
              pc_reg <= a1;
            end else begin
              pc_reg <= pc_reg + 16'd2;
            end
          end else if (!in_mem({1'b0, a1}) ||
                       (op == OP_COPY && !in_mem({1'b0, a2}))) begin
            halt_code <= ST_BADADDR;
            state <= S_OUT;
          end else begin
            state <= S_DATA;
          end
        end
        S_DATA: begin
          d1 <= rd_data;
          state <= S_ALU;
        end
        S_ALU: begin
          state <= (op == OP_DIV && d1 != 16'd0) ? S_DIV : S_OUT;
          pc_reg <= (op == OP_DIV && d1 == 16'd0) ? pc_reg : pc_reg + 16'(len);
          case (op)
            OP_ADD: acc_reg <= acc_reg + d1;
            OP_SUB: acc_reg <= acc_reg - d1;
            OP_MUL: acc_reg <= 16'(acc_reg * d1);
            OP_DIV: begin
              if (d1 == 16'd0) begin
                halt_code <= ST_DIVZERO;
              end else begin
                quo <= acc_reg[15] ? 16'(-acc_reg) : acc_reg;
                dvs <= d1[15] ? 16'(-d1) : d1;
                neg_q <= acc_reg[15] ^ d1[15];
                rem_r <= '0;
                div_cnt <= '0;
              end
            end
            OP_COPY: begin
              wr_addr <= a2[AW-1:0];
              wr_data <= d1;
            end
            OP_LOAD: acc_reg <= d1;
            OP_STORE: begin
              wr_addr <= a1[AW-1:0];
              wr_data <= acc_reg;
            end
            OP_INPUT: begin
              wr_addr <= a1[AW-1:0];
              wr_data <= in_value;
              taken <= 1'b1;
            end
            default: begin
              ovalid <= 1'b1;
              oval <= d1;
            end
          endcase
        end
        S_DIV: begin
          if (!rem_sh[16]) begin
            rem_r <= rem_sh[15:0];
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem_r <= {rem_r[14:0], quo[15]};
            quo <= {quo[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd15) begin
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          acc_reg <= neg_q ? 16'(-quo) : quo;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          status <= halt_code;
          program_counter <= pc_reg;
          accumulator <= acc_reg;
          input_taken <= taken;
          output_valid <= ovalid;
          output_value <= oval;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while a result waits");

  a_fault_clears_io: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_RUN) |-> (!input_taken && !output_valid))
    else $error("halted result carries io flags");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready after transfer");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import acm_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  address;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pc;
    logic [15:0] acc;
    logic        taken;
    logic        ovalid;
    logic [15:0] oval;
  } snap_t;

  localparam int MemWords = 256;
  localparam int WatchLimit = 4000;
  localparam logic [1:0] KindUnused = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [7:0] address = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] status;
  logic [15:0] program_counter;
  logic signed [15:0] accumulator;
  logic input_taken;
  logic output_valid;
  logic signed [15:0] output_value;

  accumulator_machine_core dut (.*);

  always #6 clk = ~clk;

  // machine model
  logic [15:0] mem_m [MemWords];
  logic [15:0] pc_m;
  logic [15:0] acc_m;
  logic [2:0]  halt_m;

  cmd_t  pending[$];
  snap_t expected[$];
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    errors = 0;
  int    idle_cycles = 0;
  bit    stim_done = 0;

  function automatic bit in_mem(logic [16:0] a);
    return a < MemWords;
  endfunction

  function automatic snap_t machine_apply(cmd_t c);
    snap_t r;
    logic [15:0] op, a1, a2, d1;
    int len;
    logic signed [15:0] sa, sd;
    bit take;
    r = '0;
    if (c.kind == KIND_LOAD) begin
      if (in_mem({9'd0, c.address})) mem_m[c.address] = c.value;
    end else if (c.kind == KIND_RESTART) begin
      pc_m = 0; acc_m = 0; halt_m = ST_RUN;
    end else if (c.kind == KIND_STEP && halt_m == ST_RUN) begin
      if (!in_mem({1'b0, pc_m})) halt_m = ST_PCPAST;
      else begin
        op = mem_m[pc_m[7:0]];
        if (op < OP_ADD || op > OP_STOP) halt_m = ST_BADOP;
        else begin
          len = (op == OP_STOP) ? 1 : (op == OP_COPY) ? 3 : 2;
          if (!in_mem(17'({1'b0, pc_m} + len - 1))) halt_m = ST_PCPAST;
          else begin
            a1 = (len >= 2) ? mem_m[8'(pc_m + 16'd1)] : '0;
            a2 = (len == 3) ? mem_m[8'(pc_m + 16'd2)] : '0;
            if (op == OP_STOP) halt_m = ST_STOP;
            else if (op >= OP_JMP && op <= OP_JMPZ) begin
              sa = acc_m;
              take = (op == OP_JMP) || (op == OP_JMPN && sa < 0) ||
                     (op == OP_JMPP && sa > 0) || (op == OP_JMPZ && sa == 0);
              pc_m = take ? a1 : pc_m + 16'd2;
            end else if (!in_mem({1'b0, a1}) || (op == OP_COPY && !in_mem({1'b0, a2})))
              halt_m = ST_BADADDR;
            else begin
              d1 = mem_m[a1[7:0]];
              if (op == OP_DIV && d1 == 0) halt_m = ST_DIVZERO;
              else begin
                case (op)
                  OP_ADD: acc_m = acc_m + d1;
                  OP_SUB: acc_m = acc_m - d1;
                  OP_MUL: acc_m = acc_m * d1;
                  OP_DIV: begin
                    sa = acc_m; sd = d1;
                    acc_m = (sa == -16'sd32768 && sd == -16'sd1) ? sa : sa / sd;
                  end
                  OP_COPY: mem_m[a2[7:0]] = d1;
                  OP_LOAD: acc_m = d1;
                  OP_STORE: mem_m[a1[7:0]] = acc_m;
                  OP_INPUT: begin mem_m[a1[7:0]] = c.value; r.taken = 1; end
                  default: begin r.ovalid = 1; r.oval = d1; end
                endcase
                pc_m = pc_m + 16'(len);
              end
            end
          end
        end
      end
    end
    r.status = halt_m; r.pc = pc_m; r.acc = acc_m;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected.push_back(machine_apply({kind, address, value}));
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_t c;
          c = pending.pop_front();
          in_valid <= 1; kind <= c.kind; address <= c.address; value <= c.value;
        end else in_valid <= 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected.size() == 0) begin
        $error("unexpected result transfer"); errors++;
      end else begin
        snap_t e;
        e = expected.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++; end
        if (program_counter !== e.pc) begin
          $error("program_counter exp %0d got %0d", e.pc, program_counter); errors++; end
        if (accumulator !== e.acc) begin
          $error("accumulator exp %0d got %0d", $signed(e.acc), accumulator); errors++; end
        if (input_taken !== e.taken) begin
          $error("input_taken exp %0d got %0d", e.taken, input_taken); errors++; end
        if (output_valid !== e.ovalid) begin
          $error("output_valid exp %0d got %0d", e.ovalid, output_valid); errors++; end
        if (output_value !== e.oval) begin
          $error("output_value exp %0d got %0d", $signed(e.oval), output_value); errors++;
        end
      end
    end
  end

  // watchdog, counted from reset, with margin for the memory clearing pass
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit + MemWords) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic push(logic [1:0] k, logic [7:0] a, logic [15:0] v);
    pending.push_back({k, a, v});
  endtask

  task automatic load_prog(int base, logic [15:0] w0, logic [15:0] w1, logic [15:0] w2);
    push(KIND_LOAD, 8'(base), w0);
    push(KIND_LOAD, 8'(base + 1), w1);
    push(KIND_LOAD, 8'(base + 2), w2);
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'(int'($urandom_range(4)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_operand();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'(MemWords - 1);
    if (r == 2) return 16'(MemWords);
    return 16'($urandom_range(200, 230));
  endfunction

  // random program: mostly well-formed instructions at low addresses
  task automatic random_program(int items);
    int n, pc;
    logic [15:0] op;
    n = 0;
    push(KIND_RESTART, 8'($urandom), 16'($urandom));
    for (int d = 200; d <= 230; d += 3) push(KIND_LOAD, 8'(d), rand_word());
    while (n < items) begin
      pc = 0;
      for (int i = 0; i < 8; i++) begin
        op = ($urandom_range(19) == 0) ? 16'($urandom_range(15)) :
             16'($urandom_range(OP_ADD, OP_STOP));
        if ($urandom_range(9) == 0) op = 16'($urandom);
        if (op == OP_STOP && $urandom_range(2) != 0) op = 16'(OP_ADD);
        load_prog(pc, op,
                  (op >= OP_JMP && op <= OP_JMPZ) ?
                    16'($urandom_range(9) == 0 ? $urandom : 2 * $urandom_range(7)) :
                    rand_operand(),
                  rand_operand());
        pc += 3;
        if (pc > 20) break;
      end
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(19))
          0: push(KIND_RESTART, 8'($urandom), 16'($urandom));
          1: push(KIND_LOAD, 8'($urandom), 16'($urandom));
          2: push(KindUnused, 8'($urandom), 16'($urandom));
          default: push(KIND_STEP, 8'($urandom), rand_word());
        endcase
      end
      n += 30;
    end
  endtask

  initial begin
    for (int i = 0; i < MemWords; i++) mem_m[i] = '0;
    pc_m = 0; acc_m = 0; halt_m = ST_RUN;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed: arithmetic, io, jumps, copy, divide corners, faults
    push(KIND_STEP, 8'hff, 16'hffff);
    push(KIND_RESTART, 8'd0, 16'd0);
    push(KIND_LOAD, 8'd250, 16'h8000);
    push(KIND_LOAD, 8'd251, 16'hffff);
    load_prog(0, 16'(OP_LOAD), 16'd250, 16'(OP_DIV));
    load_prog(3, 16'd251, 16'(OP_INPUT), 16'd252);
    load_prog(6, 16'(OP_OUTPUT), 16'd252, 16'(OP_COPY));
    load_prog(9, 16'd252, 16'd253, 16'(OP_JMPN));
    push(KIND_LOAD, 8'd12, 16'd14);
    load_prog(14, 16'(OP_DIV), 16'd254, 16'(OP_STOP));
    for (int i = 0; i < 7; i++) push(KIND_STEP, 8'd0, 16'h7fff);
    push(KIND_LOAD, 8'd20, 16'h0);
    push(KindUnused, 8'hff, 16'hffff);
    push(KIND_RESTART, 8'd0, 16'd0);
    wait_drained();

    recv_stall_pct = 0; send_idle_pct = 0;
    random_program(80);
    wait_drained();
    send_idle_pct = 70;
    random_program(80);
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 70;
    random_program(80);
    wait_drained();
    send_idle_pct = 37; recv_stall_pct = 37;
    random_program(80);
    wait_drained();
    repeat (60) @(posedge clk);

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
